FILE: hdl/stc_pkg.sv
// ----------------------------------------------------------------------------
// Space-to-tab compressor package
// Shared widths, character codes, register indexes, sequencer states and the
// count saturation helper used by the compressor.
// ----------------------------------------------------------------------------
package stc_pkg;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 16;
    localparam int STOP_W     = 16;
    localparam int INDEX_W    = 4;
    localparam int SCOUNT_W   = 5;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NL  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;

    // Reset value of the uniform tab spacing
    localparam logic [STOP_W-1:0] DEFAULT_WIDTH_RST = 16'd8;

    // Configuration register indexes (word address bits)
    typedef enum logic [1:0] {
        REG_CONVERT_ALL   = 2'd0,
        REG_STOP_COUNT    = 2'd1,
        REG_DEFAULT_WIDTH = 2'd2
    } reg_index_t;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LDW  = 6'b000010,
        S_MOD  = 6'b000100,
        S_DIV  = 6'b001000,
        S_SCAN = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    // Clamp a count of up to 33 bits to the 16-bit repeat field.
    function automatic logic [COUNT_W-1:0] sat_count(input logic [32:0] v);
        logic [COUNT_W-1:0] r;
        r = (v > 33'd65535) ? 16'hFFFF : v[COUNT_W-1:0];
        return r;
    endfunction

endpackage

FILE: hdl/space_to_tab_compressor_unit.sv
// ----------------------------------------------------------------------------
// Space-to-tab compressor
// Turns a stream of text bytes into run-length coded transactions, replacing
// runs of spaces that end on a tab stop with tabs. Tab stops are uniform or
// taken from a programmable list held in a small memory.
// ----------------------------------------------------------------------------
// One transaction is taken at a time; the input stalls outside the idle state.
// A command or a space that cannot convert completes in the idle state. A
// newline or another byte then delivers its results in order, held while the
// output stalls. A space with uniform stops runs the shared restoring divider
// (remainder check, then tab count). A space with a stop list walks the list
// in index order through the single read port of the stop memory.
// Reset clears column, run start and line state and returns the configuration
// to its reset values; the stop list is undefined until written.
module space_to_tab_compressor_unit #(
    parameter int MAX_STOPS   = 16,
    parameter int COLUMN_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [stc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [stc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [stc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    // Input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic [stc_pkg::BYTE_W-1:0]         text_byte,
    input  logic [stc_pkg::INDEX_W-1:0]        stop_index,
    input  logic [stc_pkg::STOP_W-1:0]         stop_value,
    // Output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [stc_pkg::BYTE_W-1:0]         out_byte,
    output logic [stc_pkg::COUNT_W-1:0]        repeat_res,
    output logic                               last
);

    localparam int IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int CNT_W = $clog2(MAX_STOPS + 1);
    localparam int DCW   = $clog2(COLUMN_BITS + 1);
    localparam int CMP_W = (COLUMN_BITS > stc_pkg::STOP_W) ? COLUMN_BITS : stc_pkg::STOP_W;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

    // Configuration registers
    logic                          convert_all_reg;
    logic [stc_pkg::SCOUNT_W-1:0]  stop_count_reg;
    logic [stc_pkg::STOP_W-1:0]    default_width_reg;

    // Line state
    stc_pkg::state_t               state_reg, state_next;
    logic [COLUMN_BITS-1:0]        column_reg, column_next;
    logic [COLUMN_BITS-1:0]        run_begin_reg, run_begin_next;
    logic                          seen_reg, seen_next;

    // Shared divider
    logic [stc_pkg::STOP_W-1:0]    w_reg, w_next;
    logic [COLUMN_BITS-1:0]        div_num_reg, div_num_next;
    logic [stc_pkg::STOP_W:0]      div_rem_reg, div_rem_next;
    logic [DCW-1:0]                div_cnt_reg, div_cnt_next;

    // Stop list scan
    logic [CNT_W-1:0]              scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]              scan_len_reg, scan_len_next;
    logic [COLUMN_BITS-1:0]        scan_c_reg, scan_c_next;
    logic [CNT_W-1:0]              scan_tabs_reg, scan_tabs_next;
    logic                          scan_match_reg, scan_match_next;
    logic                          scan_brk_reg, scan_brk_next;

    // Pending results of the current transaction
    logic [stc_pkg::BYTE_W-1:0]    res0_byte_reg, res0_byte_next;
    logic [stc_pkg::COUNT_W-1:0]   res0_cnt_reg, res0_cnt_next;
    logic [stc_pkg::BYTE_W-1:0]    res1_byte_reg, res1_byte_next;
    logic [stc_pkg::COUNT_W-1:0]   res1_cnt_reg, res1_cnt_next;
    logic                          res_two_reg, res_two_next;
    logic                          emit_sel_reg, emit_sel_next;

    // Output register
    logic                          out_valid_reg, out_valid_next;
    logic [stc_pkg::BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic [stc_pkg::COUNT_W-1:0]   out_cnt_reg, out_cnt_next;
    logic                          out_last_reg, out_last_next;

    // Stop memory
    logic [stc_pkg::STOP_W-1:0]    stop_mem [MAX_STOPS];
    logic [stc_pkg::STOP_W-1:0]    rd_data_reg;
    logic [IDX_W-1:0]              rd_addr;
    logic [IDX_W-1:0]              wr_addr;
    logic                          wr_en;

    // Datapath helpers
    logic                          in_acc;
    logic                          cfg_wr;
    logic [COLUMN_BITS-1:0]        col_inc;
    logic [COLUMN_BITS-1:0]        flush_cnt;
    logic                          can_convert;
    logic [CNT_W-1:0]              list_len;
    logic [stc_pkg::STOP_W:0]      rem_shift;
    logic                          sub_ok;
    logic [CMP_W-1:0]              t_ext, c_ext, col_ext;
    logic                          proc_en;
    logic                          m_new, brk_new;
    logic [COLUMN_BITS-1:0]        c_new;
    logic [CNT_W-1:0]              tabs_new;
    logic [COLUMN_BITS:0]          tabs_uni;
    logic                          slot_free;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (stc_pkg::reg_index_t'(paddr[3:2]))
            stc_pkg::REG_CONVERT_ALL:   prdata = 32'(convert_all_reg);
            stc_pkg::REG_STOP_COUNT:    prdata = 32'(stop_count_reg);
            stc_pkg::REG_DEFAULT_WIDTH: prdata = 32'(default_width_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            convert_all_reg   <= 1'b0;
            stop_count_reg    <= '0;
            default_width_reg <= stc_pkg::DEFAULT_WIDTH_RST;
        end
        else if (cfg_wr)
        begin
            case (stc_pkg::reg_index_t'(paddr[3:2]))
                stc_pkg::REG_CONVERT_ALL:   convert_all_reg   <= pwdata[0];
                stc_pkg::REG_STOP_COUNT:    stop_count_reg    <= pwdata[stc_pkg::SCOUNT_W-1:0];
                stc_pkg::REG_DEFAULT_WIDTH: default_width_reg <= pwdata[stc_pkg::STOP_W-1:0];
                default:                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stop list memory: one write port, one registered read port
    // ------------------------------------------------------------------------
    assign in_stall = (state_reg != stc_pkg::S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign wr_en    = in_acc && command && (32'(stop_index) < MAX_STOPS);
    assign wr_addr  = IDX_W'(stop_index);
    assign rd_addr  = (state_reg == stc_pkg::S_SCAN) ? scan_idx_reg[IDX_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stop_mem[wr_addr] <= stop_value;
        end
        rd_data_reg <= stop_mem[rd_addr];
    end

    // ------------------------------------------------------------------------
    // Shared helpers: column step, flush count, divider step, list compare
    // ------------------------------------------------------------------------
    assign col_inc     = (column_reg == COL_MAX) ? column_reg : column_reg + 1'b1;
    assign flush_cnt   = column_reg - run_begin_reg;
    assign can_convert = convert_all_reg || !seen_reg;
    assign list_len    = (32'(stop_count_reg) > MAX_STOPS) ? CNT_W'(MAX_STOPS)
                                                           : CNT_W'(stop_count_reg);

    // One restoring division step per cycle
    assign rem_shift = {div_rem_reg[stc_pkg::STOP_W-1:0], div_num_reg[COLUMN_BITS-1]};
    assign sub_ok    = (rem_shift >= {1'b0, w_reg});

    // Ceiling of run length over the spacing
    assign tabs_uni = (COLUMN_BITS+1)'(div_num_reg) + (COLUMN_BITS+1)'(div_rem_reg != '0);

    // One list entry per cycle: stop match and next-stop walk in index order
    assign t_ext   = CMP_W'(rd_data_reg);
    assign c_ext   = CMP_W'(scan_c_reg);
    assign col_ext = CMP_W'(column_reg);
    assign proc_en = (state_reg == stc_pkg::S_SCAN) && (scan_idx_reg != '0);

    always_comb
    begin
        m_new    = scan_match_reg;
        brk_new  = scan_brk_reg;
        c_new    = scan_c_reg;
        tabs_new = scan_tabs_reg;
        if (proc_en)
        begin
            if (t_ext == col_ext)
            begin
                m_new = 1'b1;
            end
            if (!scan_brk_reg && (t_ext > c_ext))
            begin
                if (t_ext > col_ext)
                begin
                    brk_new = 1'b1;
                end
                else
                begin
                    c_new    = t_ext[COLUMN_BITS-1:0];
                    tabs_new = scan_tabs_reg + 1'b1;
                end
            end
        end
    end

    assign slot_free = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        column_next     = column_reg;
        run_begin_next  = run_begin_reg;
        seen_next       = seen_reg;
        w_next          = w_reg;
        div_num_next    = div_num_reg;
        div_rem_next    = div_rem_reg;
        div_cnt_next    = div_cnt_reg;
        scan_idx_next   = scan_idx_reg;
        scan_len_next   = scan_len_reg;
        scan_c_next     = scan_c_reg;
        scan_tabs_next  = scan_tabs_reg;
        scan_match_next = scan_match_reg;
        scan_brk_next   = scan_brk_reg;
        res0_byte_next  = res0_byte_reg;
        res0_cnt_next   = res0_cnt_reg;
        res1_byte_next  = res1_byte_reg;
        res1_cnt_next   = res1_cnt_reg;
        res_two_next    = res_two_reg;
        emit_sel_next   = emit_sel_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_byte_next   = out_byte_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            stc_pkg::S_IDLE:
            begin
                if (in_acc && !command)
                begin
                    emit_sel_next = 1'b0;
                    if (text_byte == stc_pkg::CH_SP)
                    begin
                        column_next = col_inc;
                        if (can_convert)
                        begin
                            if (stop_count_reg == '0)
                            begin
                                // Uniform stops at the default spacing
                                w_next       = default_width_reg;
                                div_num_next = col_inc;
                                div_rem_next = '0;
                                div_cnt_next = DCW'(COLUMN_BITS);
                                if (default_width_reg != '0)
                                begin
                                    state_next = stc_pkg::S_MOD;
                                end
                            end
                            else if (stop_count_reg == 5'd1)
                            begin
                                // Spacing comes from the first list entry
                                state_next = stc_pkg::S_LDW;
                            end
                            else
                            begin
                                scan_idx_next   = '0;
                                scan_len_next   = list_len;
                                scan_c_next     = run_begin_reg;
                                scan_tabs_next  = '0;
                                scan_match_next = 1'b0;
                                scan_brk_next   = 1'b0;
                                state_next      = stc_pkg::S_SCAN;
                            end
                        end
                    end
                    else
                    begin
                        // Flush pending spaces, then pass the byte through
                        if (column_reg > run_begin_reg)
                        begin
                            res0_byte_next = stc_pkg::CH_SP;
                            res0_cnt_next  = stc_pkg::sat_count(33'(flush_cnt));
                            res1_byte_next = text_byte;
                            res1_cnt_next  = 16'd1;
                            res_two_next   = 1'b1;
                        end
                        else
                        begin
                            res0_byte_next = text_byte;
                            res0_cnt_next  = 16'd1;
                            res_two_next   = 1'b0;
                        end
                        if (text_byte == stc_pkg::CH_NL)
                        begin
                            column_next    = '0;
                            run_begin_next = '0;
                            seen_next      = 1'b0;
                        end
                        else
                        begin
                            column_next    = col_inc;
                            run_begin_next = col_inc;
                            seen_next      = 1'b1;
                        end
                        state_next = stc_pkg::S_EMIT;
                    end
                end
            end

            stc_pkg::S_LDW:
            begin
                w_next       = rd_data_reg;
                div_num_next = column_reg;
                div_rem_next = '0;
                div_cnt_next = DCW'(COLUMN_BITS);
                state_next   = (rd_data_reg != '0) ? stc_pkg::S_MOD : stc_pkg::S_IDLE;
            end

            stc_pkg::S_MOD:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_num_next = {div_num_reg[COLUMN_BITS-2:0], sub_ok};
                    div_rem_next = sub_ok ? rem_shift - {1'b0, w_reg} : rem_shift;
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
                else if ((div_rem_reg == '0) && (flush_cnt != '0))
                begin
                    // Column is on a stop: count the tabs for the pending run
                    div_num_next = flush_cnt;
                    div_rem_next = '0;
                    div_cnt_next = DCW'(COLUMN_BITS);
                    state_next   = stc_pkg::S_DIV;
                end
                else
                begin
                    state_next = stc_pkg::S_IDLE;
                end
            end

            stc_pkg::S_DIV:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_num_next = {div_num_reg[COLUMN_BITS-2:0], sub_ok};
                    div_rem_next = sub_ok ? rem_shift - {1'b0, w_reg} : rem_shift;
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
                else
                begin
                    res0_byte_next = stc_pkg::CH_TAB;
                    res0_cnt_next  = stc_pkg::sat_count(33'(tabs_uni));
                    res_two_next   = 1'b0;
                    run_begin_next = column_reg;
                    state_next     = stc_pkg::S_EMIT;
                end
            end

            stc_pkg::S_SCAN:
            begin
                scan_match_next = m_new;
                scan_brk_next   = brk_new;
                scan_c_next     = c_new;
                scan_tabs_next  = tabs_new;
                if (scan_idx_reg == scan_len_reg)
                begin
                    state_next = stc_pkg::S_IDLE;
                    if (m_new)
                    begin
                        run_begin_next = column_reg;
                        if (tabs_new != '0)
                        begin
                            res0_byte_next = stc_pkg::CH_TAB;
                            res0_cnt_next  = stc_pkg::sat_count(33'(tabs_new));
                            res1_byte_next = stc_pkg::CH_SP;
                            res1_cnt_next  = stc_pkg::sat_count(33'(column_reg - c_new));
                            res_two_next   = (column_reg > c_new);
                            state_next     = stc_pkg::S_EMIT;
                        end
                        else if (column_reg > c_new)
                        begin
                            res0_byte_next = stc_pkg::CH_SP;
                            res0_cnt_next  = stc_pkg::sat_count(33'(column_reg - c_new));
                            res_two_next   = 1'b0;
                            state_next     = stc_pkg::S_EMIT;
                        end
                    end
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            stc_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = emit_sel_reg ? res1_byte_reg : res0_byte_reg;
                    out_cnt_next   = emit_sel_reg ? res1_cnt_reg : res0_cnt_reg;
                    out_last_next  = emit_sel_reg || !res_two_reg;
                    if (emit_sel_reg || !res_two_reg)
                    begin
                        state_next = stc_pkg::S_IDLE;
                    end
                    else
                    begin
                        emit_sel_next = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = stc_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stc_pkg::S_IDLE;
            column_reg    <= '0;
            run_begin_reg <= '0;
            seen_reg      <= 1'b0;
            emit_sel_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            column_reg    <= column_next;
            run_begin_reg <= run_begin_next;
            seen_reg      <= seen_next;
            emit_sel_reg  <= emit_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        w_reg          <= w_next;
        div_num_reg    <= div_num_next;
        div_rem_reg    <= div_rem_next;
        div_cnt_reg    <= div_cnt_next;
        scan_idx_reg   <= scan_idx_next;
        scan_len_reg   <= scan_len_next;
        scan_c_reg     <= scan_c_next;
        scan_tabs_reg  <= scan_tabs_next;
        scan_match_reg <= scan_match_next;
        scan_brk_reg   <= scan_brk_next;
        res0_byte_reg  <= res0_byte_next;
        res0_cnt_reg   <= res0_cnt_next;
        res1_byte_reg  <= res1_byte_next;
        res1_cnt_reg   <= res1_cnt_next;
        res_two_reg    <= res_two_next;
        out_byte_reg   <= out_byte_next;
        out_cnt_reg    <= out_cnt_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign repeat_res = out_cnt_reg;
    assign last       = out_last_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The pending run never starts beyond the current column.
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        run_begin_reg <= column_reg)
        else $error("pending run starts beyond the column");

    // The divider only runs against a non-zero spacing.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stc_pkg::S_MOD || state_reg == stc_pkg::S_DIV) |-> (w_reg != '0))
        else $error("divider running with zero spacing");

    // A newline transaction always goes straight to result delivery.
    a_newline_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !command && text_byte == stc_pkg::CH_NL) |=>
            (state_reg == stc_pkg::S_EMIT && column_reg == '0 && !seen_reg))
        else $error("newline did not reset the line and emit");

endmodule

FILE: tb/sv/stc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Space-to-tab compressor result checker
// Watches the configuration port and both channels of the compressor, keeps
// its own copy of the column tracking, the line state and the stop list, and
// compares every output transaction field by field with the oldest predicted
// run. The failure count and the number of runs still awaited go to the top.
// ----------------------------------------------------------------------------
module stc_result_checker #(
    parameter int MAX_STOPS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [stc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [stc_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                           pready,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           command,
    input  logic [stc_pkg::BYTE_W-1:0]     text_byte,
    input  logic [stc_pkg::INDEX_W-1:0]    stop_index,
    input  logic [stc_pkg::STOP_W-1:0]     stop_value,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [stc_pkg::BYTE_W-1:0]     out_byte,
    input  logic [stc_pkg::COUNT_W-1:0]    repeat_res,
    input  logic                           last,
    output int                             runs_outstanding,
    output int                             mismatch_total
);

    localparam logic [15:0] COL_MAX = 16'hFFFF;

    typedef struct {
        logic [stc_pkg::BYTE_W-1:0]  ch;
        logic [stc_pkg::COUNT_W-1:0] count;
        logic                        is_last;
    } run_t;

    // Shadow configuration
    logic                         convert_all;
    logic [stc_pkg::SCOUNT_W-1:0] stop_count;
    logic [stc_pkg::STOP_W-1:0]   default_width;

    // Shadow line state and stop list
    logic [15:0]                  column;
    logic [15:0]                  run_begin;
    logic                         seen_nonblank;
    logic [stc_pkg::STOP_W-1:0]   stop_list [MAX_STOPS];

    // Runs still awaited, oldest first, and the runs of the current transaction
    run_t                         expected_runs [$];
    run_t                         step_runs [2];
    int                           step_n;
    int                           mismatch_count;

    function automatic int unsigned list_length();
        return (32'(stop_count) > MAX_STOPS) ? 32'(MAX_STOPS) : 32'(stop_count);
    endfunction

    function automatic int unsigned uniform_spacing();
        return (stop_count == 0) ? 32'(default_width) : 32'(stop_list[0]);
    endfunction

    // True when the given column is a tab stop under the current setting.
    function automatic logic stop_at(input int unsigned col);
        int unsigned w;
        int unsigned i;
        if (stop_count <= 1)
        begin
            w = uniform_spacing();
            return (w != 0) && ((col % w) == 0);
        end
        for (i = 0; i < list_length(); i++)
            if (32'(stop_list[i]) == col)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic add_run(input logic [stc_pkg::BYTE_W-1:0] ch, input int unsigned count);
        step_runs[step_n].ch      = ch;
        step_runs[step_n].count   = (count > 65535) ? 16'hFFFF : count[15:0];
        step_runs[step_n].is_last = 1'b0;
        step_n++;
    endtask

    task automatic flush_spaces();
        if (column > run_begin)
            add_run(stc_pkg::CH_SP, 32'(column - run_begin));
    endtask

    // Turn the pending run of spaces into tabs up to the last stop it reaches,
    // followed by whatever spaces remain beyond that stop.
    task automatic emit_pending_run();
        int unsigned tabs;
        int unsigned c;
        int unsigned w;
        int unsigned nx;
        int unsigned i;
        int unsigned it;
        logic        found;
        tabs = 0;
        c    = 32'(run_begin);
        if (stop_count <= 1)
        begin
            w = uniform_spacing();
            if (w != 0 && 32'(column) > c)
            begin
                tabs = 32'(column) / w - c / w;
                c    = (32'(column) / w) * w;
            end
        end
        else
        begin
            for (it = 0; it < MAX_STOPS; it++)
            begin
                found = 1'b0;
                nx    = 0;
                for (i = 0; i < list_length(); i++)
                begin
                    if (!found && 32'(stop_list[i]) > c)
                    begin
                        nx    = 32'(stop_list[i]);
                        found = 1'b1;
                    end
                end
                if (!found || nx > 32'(column))
                    break;
                c = nx;
                tabs++;
            end
        end
        if (tabs > 0)
            add_run(stc_pkg::CH_TAB, tabs);
        if (32'(column) > c)
            add_run(stc_pkg::CH_SP, 32'(column) - c);
    endtask

    // Predict the runs caused by one accepted input transaction.
    task automatic unexpand_step(input logic cmd, input logic [stc_pkg::BYTE_W-1:0] ch,
                                 input logic [stc_pkg::INDEX_W-1:0] idx,
                                 input logic [stc_pkg::STOP_W-1:0] val);
        int i;
        step_n = 0;
        if (cmd)
        begin
            if (32'(idx) < MAX_STOPS)
                stop_list[idx] = val;
        end
        else if (ch == stc_pkg::CH_NL)
        begin
            flush_spaces();
            add_run(stc_pkg::CH_NL, 1);
            column        = '0;
            run_begin     = '0;
            seen_nonblank = 1'b0;
        end
        else if (ch == stc_pkg::CH_SP)
        begin
            if (column < COL_MAX)
                column++;
            if (stop_at(32'(column)) && (convert_all || !seen_nonblank))
            begin
                emit_pending_run();
                run_begin = column;
            end
        end
        else
        begin
            flush_spaces();
            add_run(ch, 1);
            seen_nonblank = 1'b1;
            if (column < COL_MAX)
                column++;
            run_begin = column;
        end
        for (i = 0; i < step_n; i++)
        begin
            step_runs[i].is_last = (i == step_n - 1);
            expected_runs.push_back(step_runs[i]);
        end
    endtask

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // Configuration writes, output comparison and prediction, all sampled at
    // the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        run_t oldest;
        if (!rst_n)
        begin
            convert_all    = 1'b0;
            stop_count     = '0;
            default_width  = stc_pkg::DEFAULT_WIDTH_RST;
            column         = '0;
            run_begin      = '0;
            seen_nonblank  = 1'b0;
            mismatch_count = 0;
            expected_runs.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    stc_pkg::REG_CONVERT_ALL:   convert_all   = pwdata[0];
                    stc_pkg::REG_STOP_COUNT:    stop_count    = pwdata[stc_pkg::SCOUNT_W-1:0];
                    stc_pkg::REG_DEFAULT_WIDTH: default_width = pwdata[stc_pkg::STOP_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (expected_runs.size() == 0)
                begin
                    report_mismatch($sformatf(
                        "unexpected transaction byte %02h repeat %0d last %0b",
                        out_byte, repeat_res, last));
                end
                else
                begin
                    oldest = expected_runs.pop_front();
                    if (out_byte !== oldest.ch || repeat_res !== oldest.count
                        || last !== oldest.is_last)
                        report_mismatch($sformatf(
                            "got byte %02h repeat %0d last %0b, wanted %02h %0d %0b",
                            out_byte, repeat_res, last,
                            oldest.ch, oldest.count, oldest.is_last));
                end
            end

            if (in_valid && !in_stall)
                unexpand_step(command, text_byte, stop_index, stop_value);
        end
        runs_outstanding <= expected_runs.size();
        mismatch_total   <= mismatch_count;
    end

endmodule

FILE: tb/sv/tb_space_to_tab_compressor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Space-to-tab compressor testbench
// Drives text and stop-list transactions through the compressor under a
// series of tab-stop settings, with bursty input, an irregular output stall
// pattern and one long output hold-off. A checker beside the block predicts
// and compares every output transaction.
// ----------------------------------------------------------------------------
module tb_space_to_tab_compressor_unit;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 48;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [stc_pkg::CFG_ADDR_W-1:0] paddr;
    logic [stc_pkg::CFG_DATA_W-1:0] pwdata;
    logic [stc_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_stall;
    logic                           command;
    logic [stc_pkg::BYTE_W-1:0]     text_byte;
    logic [stc_pkg::INDEX_W-1:0]    stop_index;
    logic [stc_pkg::STOP_W-1:0]     stop_value;
    logic                           out_valid;
    logic                           out_stall;
    logic [stc_pkg::BYTE_W-1:0]     out_byte;
    logic [stc_pkg::COUNT_W-1:0]    repeat_res;
    logic                           last;

    int                             runs_outstanding;
    int                             mismatch_total;
    int                             items_sent;
    int                             burst_left;
    bit                             hold_req = 1'b0;

    space_to_tab_compressor_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .text_byte  (text_byte),
        .stop_index (stop_index),
        .stop_value (stop_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .repeat_res (repeat_res),
        .last       (last)
    );

    stc_result_checker result_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .text_byte        (text_byte),
        .stop_index       (stop_index),
        .stop_value       (stop_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .repeat_res       (repeat_res),
        .last             (last),
        .runs_outstanding (runs_outstanding),
        .mismatch_total   (mismatch_total)
    );

    // Clock generation
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Overall time limit
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // Output side: random stall modes, each held for a random span, and one
    // long hold-off on request from the stimulus.
    initial
    begin
        int mode;
        int left;
        out_stall = 1'b0;
        mode      = 0;
        left      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    0: out_stall = 1'b0;
                    1: out_stall = ($urandom_range(0, 3) == 0);
                    2: out_stall = ($urandom_range(0, 3) != 0);
                    default: out_stall = (left % 3 == 0);
                endcase
            end
        end
    end

    // Offer one transaction and hold it until it is accepted. Bursts of
    // random length are separated by random gaps.
    task automatic send_item(input logic cmd, input logic [stc_pkg::BYTE_W-1:0] ch,
                             input logic [stc_pkg::INDEX_W-1:0] idx,
                             input logic [stc_pkg::STOP_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        command    = cmd;
        text_byte  = ch;
        stop_index = idx;
        stop_value = val;
        in_valid   = 1'b1;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_text(input logic [stc_pkg::BYTE_W-1:0] ch);
        send_item(1'b0, ch, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
    endtask

    // Stop offering and wait until every predicted run has arrived, then let
    // the block finish any transaction that causes no output.
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (runs_outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic reg_write(input stc_pkg::reg_index_t r,
                             input logic [stc_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {r, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic ca, input logic [stc_pkg::SCOUNT_W-1:0] sc,
                              input logic [stc_pkg::STOP_W-1:0] dw);
        reg_write(stc_pkg::REG_CONVERT_ALL, 32'(ca));
        reg_write(stc_pkg::REG_STOP_COUNT, 32'(sc));
        reg_write(stc_pkg::REG_DEFAULT_WIDTH, 32'(dw));
    endtask

    // Write all sixteen stop entries: ascending, unordered, ascending with a
    // zero entry, or ascending from one up to the largest column.
    task automatic load_stop_list(input int style);
        int          v;
        int          zero_at;
        int          i;
        logic [15:0] entry;
        v       = 0;
        zero_at = $urandom_range(0, 3);
        for (i = 0; i < 16; i++)
        begin
            case (style)
                0:
                begin
                    v += $urandom_range(1, 6);
                    entry = v[15:0];
                end
                1: entry = 16'($urandom_range(1, 40));
                2:
                begin
                    v += $urandom_range(1, 5);
                    entry = (i == zero_at) ? 16'd0 : v[15:0];
                end
                default:
                begin
                    v += $urandom_range(1, 4);
                    entry = (i == 0) ? 16'd1 : (i == 15) ? 16'hFFFF : v[15:0];
                end
            endcase
            send_item(1'b1, 8'($urandom_range(0, 255)), 4'(i), entry);
        end
    endtask

    // One line of text: leading blanks, words separated by runs of spaces,
    // optional trailing spaces, then a newline.
    task automatic send_line();
        int lead;
        int words;
        int wlen;
        int k;
        int j;
        lead  = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        words = $urandom_range(0, 4);
        repeat (lead) send_text(stc_pkg::CH_SP);
        for (k = 0; k < words; k++)
        begin
            wlen = $urandom_range(1, 7);
            for (j = 0; j < wlen; j++)
                send_text(8'($urandom_range(33, 126)));
            repeat ($urandom_range((k == words - 1) ? 0 : 1, 12)) send_text(stc_pkg::CH_SP);
        end
        send_text(stc_pkg::CH_NL);
    endtask

    // Stray bytes of any value, input tabs and stop-list writes.
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_text(8'($urandom_range(0, 255)));
            1: send_text(stc_pkg::CH_TAB);
            2: send_item(1'b1, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                         16'($urandom_range(1, 40)));
            default: send_item(1'b1, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                               16'($urandom_range(0, 65535)));
        endcase
    endtask

    // Main stimulus
    initial
    begin
        int p;
        int phase_goal;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        command    = 1'b0;
        text_byte  = '0;
        stop_index = '0;
        stop_value = '0;
        items_sent = 0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset setting: stop-list writes at the
        // extremes, leading blanks reaching a stop, a flush before a letter,
        // an input tab, extreme byte values and a newline flushing spaces.
        send_item(1'b1, 8'h00, 4'd0, 16'd1);
        send_item(1'b1, 8'hFF, 4'd15, 16'hFFFF);
        repeat (9) send_text(stc_pkg::CH_SP);
        send_text(8'h41);
        send_text(stc_pkg::CH_SP);
        send_text(stc_pkg::CH_TAB);
        send_text(8'hFF);
        send_text(8'h00);
        repeat (7) send_text(stc_pkg::CH_SP);
        send_text(stc_pkg::CH_NL);

        // Random phases, each under its own tab-stop setting.
        for (p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: ;
                1: set_config(1'b1, 5'd0, 16'd1);
                2: set_config(1'b1, 5'd0, 16'hFFFF);
                3:
                begin
                    set_config(1'b0, 5'd1, 16'($urandom_range(1, 16)));
                    load_stop_list(0);
                end
                4: set_config(1'b1, 5'd16, 16'($urandom_range(1, 16)));
                5:
                begin
                    set_config(1'b1, 5'd3, 16'($urandom_range(1, 16)));
                    load_stop_list(1);
                end
                6:
                begin
                    set_config(1'b0, 5'd5, 16'($urandom_range(1, 16)));
                    load_stop_list(2);
                end
                7:
                begin
                    set_config(1'b1, 5'd31, 16'($urandom_range(1, 16)));
                    load_stop_list(3);
                end
                8: set_config(1'b1, 5'd0, 16'd0);
                9:
                begin
                    set_config(1'b1, 5'd2, 16'($urandom_range(1, 16)));
                    load_stop_list(0);
                end
                10: set_config(1'b0, 5'd0, 16'($urandom_range(2, 12)));
                default:
                begin
                    set_config(1'b1, 5'd1, 16'($urandom_range(1, 16)));
                    load_stop_list(1);
                end
            endcase

            phase_goal = items_sent + ITEMS_PER_PHASE;
            if (p == 4)
            begin
                // Long output hold-off while input keeps coming.
                repeat (3) send_line();
                hold_req = 1'b1;
            end
            if (p == 6)
            begin
                // Pause the input until every run has arrived.
                repeat (3) send_line();
                wait_idle();
            end
            while (items_sent < phase_goal)
            begin
                if ($urandom_range(0, 9) < 8)
                    send_line();
                else
                    send_noise();
            end
        end

        wait_idle();
        if (mismatch_total == 0 && runs_outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
